>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the vertex attribute converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define VATF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("vatf assertion failed");

// Same-cycle implication.
`define VATF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vatf implication failed");

// Next-cycle implication.
`define VATF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vatf next-cycle implication failed");

`endif

>>> rtl/vatf_pkg.sv
// Package with the types, format codes and constants of the vertex attribute converter.
`default_nettype none
package vatf_pkg;

    // Attribute format codes.
    localparam logic [2:0] FMT_INVALID = 3'd0;
    localparam logic [2:0] FMT_SNORM16 = 3'd1;
    localparam logic [2:0] FMT_FLOAT32 = 3'd2;
    localparam logic [2:0] FMT_HALF    = 3'd3;
    localparam logic [2:0] FMT_UNORM8  = 3'd4;
    localparam logic [2:0] FMT_SINT16  = 3'd5;
    localparam logic [2:0] FMT_PACKED  = 3'd6;
    localparam logic [2:0] FMT_UINT8   = 3'd7;

    // Register indexes.
    localparam logic REG_TYPE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    localparam logic [2:0] TYPE_RESET  = FMT_FLOAT32;
    localparam logic [2:0] COUNT_RESET = 3'd4;

    localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
    localparam logic [31:0] FP_NEG_OVER = 32'hBF80_0100;
    localparam logic [30:0] FP_QNAN     = 31'h7FC0_0000;
    localparam logic [30:0] FP_INF      = 31'h7F80_0000;

    // How a lane finishes its conversion.
    typedef enum logic [1:0] {
        KIND_RAW = 2'd0,
        KIND_INT = 2'd1,
        KIND_DIV = 2'd2
    } lane_kind_t;

    // Divisor 2^k - 1 for the scaled formats.
    typedef enum logic [1:0] {
        DW_8  = 2'd0,
        DW_15 = 2'd1,
        DW_16 = 2'd2
    } div_width_t;

    typedef struct packed {
        lane_kind_t  kind;
        logic        sign;
        logic        sub;
        div_width_t  dw;
        logic [15:0] mag;
        logic [31:0] bits;
    } lane_s1_t;

    typedef struct packed {
        lane_kind_t  kind;
        logic        sign;
        logic        sub;
        logic [3:0]  lz;
        logic [24:0] frac;
        logic [31:0] bits;
    } lane_s2_t;

endpackage
`default_nettype wire

>>> rtl/vertex_attribute_to_float.sv
// Top level of the vertex attribute converter: register port, pipeline and handshake.
`default_nettype none
`include "assert_macros.svh"
// Converts one 16-byte big-endian vertex attribute per request into four IEEE single
// words (x, y, z, w) in the format chosen by the attr_type and component_count registers.
// The pipeline accepts one request per clock while s_ready is high and carries each result
// through its three register stages: decode, normalize, round. Each stage holds its item
// while the next one cannot take it, so the input keeps taking requests as long as some
// stage is empty or the output is taken. Registers sit at byte 0 (attr_type) and byte 4
// (component_count) and should be written only while the pipeline is empty.
module vertex_attribute_to_float (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_bytes_first_half,
    input  wire logic [63:0] s_bytes_second_half,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_ok,
    output logic [31:0]      m_x_value,
    output logic [31:0]      m_y_value,
    output logic [31:0]      m_z_value,
    output logic [31:0]      m_w_value
);
    import vatf_pkg::*;

    logic [2:0]  type_reg;
    logic [2:0]  count_reg;
    logic        cfg_write;

    logic        v1_reg, v2_reg, v3_reg;
    logic        rdy1, rdy2, rdy3;
    logic        ok1_reg, ok2_reg, ok3_reg;
    lane_s1_t [3:0] s1_reg;
    lane_s1_t [3:0] s1_next;
    lane_s2_t [3:0] s2_reg;
    lane_s2_t [3:0] s2_next;
    logic [3:0][31:0] s3_reg;
    logic [3:0][31:0] s3_next;
    logic        ok_next;
    logic [31:0] out_bits_or;

    // Register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_COUNT) ? {29'h0, count_reg} : {29'h0, type_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_reg  <= TYPE_RESET;
            count_reg <= COUNT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_TYPE) begin
                type_reg <= pwdata[2:0];
            end else begin
                count_reg <= pwdata[2:0];
            end
        end
    end

    // Each stage moves when it is empty or the stage after it can take its item.
    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    vatf_fetch u_fetch (
        .attr_type         (type_reg),
        .component_count   (count_reg),
        .bytes_first_half  (s_bytes_first_half),
        .bytes_second_half (s_bytes_second_half),
        .ok                (ok_next),
        .lane_o            (s1_next)
    );

    for (genvar g = 0; g < 4; g++) begin : g_lane
        vatf_norm u_norm (
            .lane_i (s1_reg[g]),
            .lane_o (s2_next[g])
        );
        vatf_pack u_pack (
            .lane_i (s2_reg[g]),
            .bits_o (s3_next[g])
        );
    end

    // Valid bits of the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage payloads load only when a valid item moves in.
    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            s1_reg  <= s1_next;
            ok1_reg <= ok_next;
        end
        if (rdy2 && v1_reg) begin
            s2_reg  <= s2_next;
            ok2_reg <= ok1_reg;
        end
        if (rdy3 && v2_reg) begin
            s3_reg  <= s3_next;
            ok3_reg <= ok2_reg;
        end
    end

    assign m_valid   = v3_reg;
    assign m_ok      = ok3_reg;
    assign m_x_value = s3_reg[0];
    assign m_y_value = s3_reg[1];
    assign m_z_value = s3_reg[2];
    assign m_w_value = s3_reg[3];

    // All value bits of the result, used to check that a rejected request gives zeros.
    assign out_bits_or = m_x_value | m_y_value | m_z_value | m_w_value;

    `VATF_ASSERT_IMPL(a_bad_cfg_zero, aclk, aresetn, m_valid && !m_ok, out_bits_or == 32'h0)
    `VATF_ASSERT_IMPL(a_full_when_blocked, aclk, aresetn, !s_ready, v1_reg && v2_reg && v3_reg)
    `VATF_ASSERT_NEXT(a_stage1_holds, aclk, aresetn, v1_reg && !rdy2, v1_reg && $stable(s1_reg))
    `VATF_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(s3_reg))

endmodule
`default_nettype wire

>>> rtl/vatf_fetch.sv
// Decode stage: picks the components out of the attribute bytes and classifies each lane.
`default_nettype none
module vatf_fetch (
    input  wire logic [2:0]                 attr_type,
    input  wire logic [2:0]                 component_count,
    input  wire logic [63:0]                bytes_first_half,
    input  wire logic [63:0]                bytes_second_half,
    output logic                            ok,
    output vatf_pkg::lane_s1_t [3:0]        lane_o
);
    import vatf_pkg::*;

    logic [127:0] bytes_w;
    logic [2:0]   count_eff;
    logic [31:0]  packed_word;

    function automatic lane_s1_t raw_lane(input logic [31:0] bits);
        lane_s1_t l;
        l.kind = KIND_RAW;
        l.sign = bits[31];
        l.sub  = 1'b0;
        l.dw   = DW_16;
        l.mag  = 16'h0;
        l.bits = bits;
        return l;
    endfunction

    function automatic lane_s1_t num_lane(input lane_kind_t kind, input logic sign,
                                          input logic sub, input div_width_t dw,
                                          input logic [15:0] mag);
        lane_s1_t l;
        l.kind = kind;
        l.sign = sign;
        l.sub  = sub;
        l.dw   = dw;
        l.mag  = mag;
        l.bits = 32'h0;
        return l;
    endfunction

    // One field of the packed format, left-aligned to 16 bits and scaled by 1/32767.
    function automatic lane_s1_t packed_lane(input logic [15:0] s16);
        logic [15:0] mag;
        lane_s1_t    l;
        mag = s16[15] ? (~s16 + 16'd1) : s16;
        if (mag == 16'h0) begin
            l = raw_lane(32'h0);
        end else if (mag == 16'h8000) begin
            l = raw_lane(FP_NEG_OVER);
        end else begin
            l = num_lane(KIND_DIV, s16[15], 1'b0, DW_15, mag);
        end
        return l;
    endfunction

    function automatic lane_s1_t decode_lane(input logic [2:0] fmt, input logic [7:0] c8,
                                             input logic [15:0] c16, input logic [31:0] c32);
        logic [15:0] m16;
        logic [7:0]  hexp;
        lane_s1_t    l;
        m16  = 16'h0;
        hexp = 8'h0;
        l    = raw_lane(32'h0);
        case (fmt)
            FMT_SNORM16: begin
                m16 = c16[15] ? {~c16[14:0], 1'b1} : {c16[14:0], 1'b1};
                if (m16 == 16'hFFFF) begin
                    l = raw_lane({c16[15], FP_ONE[30:0]});
                end else begin
                    l = num_lane(KIND_DIV, c16[15], 1'b0, DW_16, m16);
                end
            end
            FMT_FLOAT32: begin
                if (c32[30:23] == 8'hFF && c32[22:0] != 23'h0) begin
                    l = raw_lane(c32 | 32'h0040_0000);
                end else begin
                    l = raw_lane(c32);
                end
            end
            FMT_HALF: begin
                hexp = {3'b000, c16[14:10]} + 8'd112;
                if (c16[14:10] == 5'd0) begin
                    if (c16[9:0] == 10'h0) begin
                        l = raw_lane({c16[15], 31'h0});
                    end else begin
                        l = num_lane(KIND_INT, c16[15], 1'b1, DW_16, {6'h0, c16[9:0]});
                    end
                end else if (c16[14:10] == 5'h1F) begin
                    l = raw_lane({c16[15], (c16[9:0] != 10'h0) ? FP_QNAN : FP_INF});
                end else begin
                    l = raw_lane({c16[15], hexp, c16[9:0], 13'h0});
                end
            end
            FMT_UNORM8: begin
                if (c8 == 8'h00) begin
                    l = raw_lane(32'h0);
                end else if (c8 == 8'hFF) begin
                    l = raw_lane(FP_ONE);
                end else begin
                    l = num_lane(KIND_DIV, 1'b0, 1'b0, DW_8, {8'h0, c8});
                end
            end
            FMT_SINT16: begin
                m16 = c16[15] ? (~c16 + 16'd1) : c16;
                if (c16 == 16'h0) begin
                    l = raw_lane(32'h0);
                end else begin
                    l = num_lane(KIND_INT, c16[15], 1'b0, DW_16, m16);
                end
            end
            FMT_UINT8: begin
                if (c8 == 8'h00) begin
                    l = raw_lane(32'h0);
                end else begin
                    l = num_lane(KIND_INT, 1'b0, 1'b0, DW_16, {8'h0, c8});
                end
            end
            default: begin
                l = raw_lane(32'h0);
            end
        endcase
        return l;
    endfunction

    assign bytes_w     = {bytes_first_half, bytes_second_half};
    assign packed_word = bytes_w[127:96];
    assign count_eff   = (attr_type == FMT_PACKED) ? 3'd1 : component_count;

    // Validity of type and count, then one decode per lane.
    always_comb begin
        ok = (attr_type != FMT_INVALID) && (count_eff != 3'd0) && (count_eff <= 3'd4);
        for (int i = 0; i < 4; i++) begin
            lane_o[i] = raw_lane(32'h0);
        end
        if (ok) begin
            if (attr_type == FMT_PACKED) begin
                lane_o[0] = packed_lane({packed_word[10:0], 5'h0});
                lane_o[1] = packed_lane({packed_word[21:11], 5'h0});
                lane_o[2] = packed_lane({packed_word[31:22], 6'h0});
                lane_o[3] = raw_lane(FP_ONE);
            end else begin
                for (int i = 0; i < 4; i++) begin
                    if (3'(i) < count_eff) begin
                        lane_o[i] = decode_lane(attr_type, bytes_w[127 - 8 * i -: 8],
                                                bytes_w[127 - 16 * i -: 16],
                                                bytes_w[127 - 32 * i -: 32]);
                    end else if (i == 3) begin
                        lane_o[i] = raw_lane(FP_ONE);
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/vatf_norm.sv
// Normalize stage: leading-zero count and left shift of one lane's magnitude.
`default_nettype none
module vatf_norm (
    input  wire vatf_pkg::lane_s1_t lane_i,
    output vatf_pkg::lane_s2_t      lane_o
);
    import vatf_pkg::*;

    logic [15:0] aligned;
    logic [15:0] src;
    logic [63:0] pattern;
    logic [63:0] shifted;
    logic [15:0] int_shifted;
    logic [3:0]  lz;

    // A quotient M / (2^k - 1) is the k-bit pattern of M repeated without end.
    always_comb begin
        case (lane_i.dw)
            DW_8: begin
                aligned = {lane_i.mag[7:0], 8'h00};
                pattern = {8{lane_i.mag[7:0]}};
            end
            DW_15: begin
                aligned = {lane_i.mag[14:0], 1'b0};
                pattern = {{4{lane_i.mag[14:0]}}, 4'h0};
            end
            default: begin
                aligned = lane_i.mag;
                pattern = {4{lane_i.mag}};
            end
        endcase
    end

    assign src = (lane_i.kind == KIND_DIV) ? aligned : lane_i.mag;

    // Leading-zero count; the magnitude is never zero on the numeric paths.
    always_comb begin
        lz = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (src[i]) begin
                lz = 4'(15 - i);
            end
        end
    end

    assign shifted     = pattern << lz;
    assign int_shifted = lane_i.mag << lz;

    always_comb begin
        lane_o.kind = lane_i.kind;
        lane_o.sign = lane_i.sign;
        lane_o.sub  = lane_i.sub;
        lane_o.lz   = lz;
        lane_o.bits = lane_i.bits;
        lane_o.frac = (lane_i.kind == KIND_DIV) ? shifted[63:39] : {int_shifted, 9'h0};
    end

endmodule
`default_nettype wire

>>> rtl/vatf_pack.sv
// Round stage: builds the single-precision word of one lane.
`default_nettype none
module vatf_pack (
    input  wire vatf_pkg::lane_s2_t lane_i,
    output logic [31:0]             bits_o
);
    import vatf_pkg::*;

    logic [23:0] div_mant;
    logic [7:0]  div_exp;
    logic [7:0]  int_exp;

    // The repeating tail is never zero, so round to nearest even is round-half-up here;
    // a period of at most 16 bits cannot hold 25 ones, so no carry out of the mantissa.
    assign div_mant = lane_i.frac[24:1] + {23'h0, lane_i.frac[0]};
    assign div_exp  = 8'd126 - {4'h0, lane_i.lz};
    assign int_exp  = 8'd142 - {4'h0, lane_i.lz} - (lane_i.sub ? 8'd24 : 8'd0);

    always_comb begin
        case (lane_i.kind)
            KIND_DIV: bits_o = {lane_i.sign, div_exp, div_mant[22:0]};
            KIND_INT: bits_o = {lane_i.sign, int_exp, lane_i.frac[23:9], 8'h0};
            default:  bits_o = lane_i.bits;
        endcase
    end

endmodule
`default_nettype wire
